/* rtl/core/dpsp_pkg.sv */
`default_nettype none

package dpsp_pkg;

   // PWM timer top value; compare = floor(PWM_TOP*(100-duty)/100)
   localparam longint unsigned PWM_TOP = 3199;

   // Divide by 100 as a multiply by a rounded-up reciprocal, exact for off <= 100
   localparam int CMP_SHIFT = 16;
   localparam longint unsigned CMP_RECIP = (PWM_TOP * (64'd1 << CMP_SHIFT) + 99) / 100;
   localparam int CMP_RECIP_W = $clog2(CMP_RECIP + 1);
   localparam int CMP_W = 12;
   localparam int CMP_PROD_W = (CMP_RECIP_W + 7 > CMP_SHIFT + CMP_W) ?
                               (CMP_RECIP_W + 7) : (CMP_SHIFT + CMP_W);

   localparam int GAIN_W = 16;
   localparam int DUTY_W = 7;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
   localparam logic [DUTY_W-1:0] DUTY_MIN  = 7'd1;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REG_KP_LEFT   = 3'd0,
      REG_KI_LEFT   = 3'd1,
      REG_KD_LEFT   = 3'd2,
      REG_KP_RIGHT  = 3'd3,
      REG_KI_RIGHT  = 3'd4,
      REG_KD_RIGHT  = 3'd5,
      REG_BASE      = 3'd6,
      REG_MAX       = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp_left;
      logic [GAIN_W-1:0] ki_left;
      logic [GAIN_W-1:0] kd_left;
      logic [GAIN_W-1:0] kp_right;
      logic [GAIN_W-1:0] ki_right;
      logic [GAIN_W-1:0] kd_right;
      logic [DUTY_W-1:0] base_speed;
      logic [DUTY_W-1:0] max_speed;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/core/dpsp_csr.sv */
`default_nettype none

module dpsp_csr import dpsp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_KP_LEFT:  cfg_in.kp_left    = pwdata[GAIN_W-1:0];
            REG_KI_LEFT:  cfg_in.ki_left    = pwdata[GAIN_W-1:0];
            REG_KD_LEFT:  cfg_in.kd_left    = pwdata[GAIN_W-1:0];
            REG_KP_RIGHT: cfg_in.kp_right   = pwdata[GAIN_W-1:0];
            REG_KI_RIGHT: cfg_in.ki_right   = pwdata[GAIN_W-1:0];
            REG_KD_RIGHT: cfg_in.kd_right   = pwdata[GAIN_W-1:0];
            REG_BASE:     cfg_in.base_speed = pwdata[DUTY_W-1:0];
            REG_MAX:      cfg_in.max_speed  = pwdata[DUTY_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KP_LEFT:  prdata = DATA_W'(cfg_ff.kp_left);
         REG_KI_LEFT:  prdata = DATA_W'(cfg_ff.ki_left);
         REG_KD_LEFT:  prdata = DATA_W'(cfg_ff.kd_left);
         REG_KP_RIGHT: prdata = DATA_W'(cfg_ff.kp_right);
         REG_KI_RIGHT: prdata = DATA_W'(cfg_ff.ki_right);
         REG_KD_RIGHT: prdata = DATA_W'(cfg_ff.kd_right);
         REG_BASE:     prdata = DATA_W'(cfg_ff.base_speed);
         REG_MAX:      prdata = DATA_W'(cfg_ff.max_speed);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_left    <= 16'd128;
         cfg_ff.ki_left    <= 16'd0;
         cfg_ff.kd_left    <= 16'd30720;
         cfg_ff.kp_right   <= 16'd133;
         cfg_ff.ki_right   <= 16'd0;
         cfg_ff.kd_right   <= 16'd30720;
         cfg_ff.base_speed <= 7'd18;
         cfg_ff.max_speed  <= 7'd25;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/differential_pid_steer_pwm.sv */
// Differential-drive PID steering with PWM compare outputs.
//
// Input channel (req_): one signed error sample per word, taken when
// req_valid is high and req_stall low. Output channel (rsp_): one word per
// input, holding both clamped duties and both timer compare values, taken
// when rsp_valid is high and rsp_stall low. Gains, base and max speed sit
// in an APB register file (psel/penable/pwrite/paddr/pwdata/prdata/pready).
//
// A ten-step control program steps one shared 17x9 multiplier through the
// six gain products: take the word, three multiply-accumulates per wheel,
// latch the right correction, clamp, and load the output. A new word is
// taken only once the program has loaded the output register with the
// result of the last one, as the single multiplier serves every product.
//
// The output register frees the sequencer: the next word is taken while a
// result still waits. If the receiver stalls long enough that the next
// result is ready too, the program holds in its output step until the
// waiting word goes. Reset clears the integral, the previous error, the
// output valid and the program counter, and restores the register defaults.
`default_nettype none

module differential_pid_steer_pwm import dpsp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic signed [7:0] req_pos_error,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DUTY_W-1:0]      rsp_duty_left,
   output logic [DUTY_W-1:0]      rsp_duty_right,
   output logic [CMP_W-1:0]       rsp_compare_left,
   output logic [CMP_W-1:0]       rsp_compare_right,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   localparam int STEP_W = 4;
   localparam int ACC_W  = 27;
   localparam int CORR_W = ACC_W - 8;
   localparam int SUM_W  = CORR_W + 1;

   typedef enum logic [2:0] {
      OP_WAIT_IN,
      OP_MAC,
      OP_NOP,
      OP_CLAMP,
      OP_WAIT_OUT
   } op_type;

   typedef enum logic [1:0] {
      SRC_ERR,
      SRC_INTEG,
      SRC_DIFF
   } src_type;

   typedef struct packed {
      op_type             op;
      src_type            src;
      reg_idx_type        gain;
      logic               acc_add;
      logic               st_left;
      logic               st_right;
      logic [STEP_W-1:0]  next;
   } ctrl_type;

   function automatic ctrl_type rom_read(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{op: OP_WAIT_IN, src: SRC_ERR, gain: REG_KP_LEFT, acc_add: 1'b0,
            st_left: 1'b0, st_right: 1'b0, next: 4'd0};
      unique case (step)
         4'd0: w.next = 4'd1;
         4'd1: w = '{OP_MAC, SRC_ERR,   REG_KP_LEFT,  1'b0, 1'b0, 1'b0, 4'd2};
         4'd2: w = '{OP_MAC, SRC_INTEG, REG_KI_LEFT,  1'b1, 1'b0, 1'b0, 4'd3};
         4'd3: w = '{OP_MAC, SRC_DIFF,  REG_KD_LEFT,  1'b1, 1'b0, 1'b0, 4'd4};
         4'd4: w = '{OP_MAC, SRC_ERR,   REG_KP_RIGHT, 1'b0, 1'b1, 1'b0, 4'd5};
         4'd5: w = '{OP_MAC, SRC_INTEG, REG_KI_RIGHT, 1'b1, 1'b0, 1'b0, 4'd6};
         4'd6: w = '{OP_MAC, SRC_DIFF,  REG_KD_RIGHT, 1'b1, 1'b0, 1'b0, 4'd7};
         4'd7: w = '{OP_NOP, SRC_ERR,   REG_KP_LEFT,  1'b0, 1'b0, 1'b1, 4'd8};
         4'd8: w = '{OP_CLAMP, SRC_ERR, REG_KP_LEFT,  1'b0, 1'b0, 1'b0, 4'd9};
         4'd9: w = '{OP_WAIT_OUT, SRC_ERR, REG_KP_LEFT, 1'b0, 1'b0, 1'b0, 4'd0};
         default: w.next = 4'd0;
      endcase
      return w;
   endfunction

   // Sum / 256, truncated toward zero
   function automatic logic signed [CORR_W-1:0] trunc_div(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] b;
      b = a[ACC_W-1] ? a + ACC_W'(255) : a;
      return b[ACC_W-1:8];
   endfunction

   function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] d,
                                                    input logic [DUTY_W-1:0]       mx);
      logic signed [SUM_W-1:0] mx_s;
      mx_s = $signed({{(SUM_W-DUTY_W){1'b0}}, mx});
      if (d > mx_s) begin
         return mx;
      end else if (d <= 0) begin
         return DUTY_MIN;
      end
      return d[DUTY_W-1:0];
   endfunction

   function automatic logic [CMP_W-1:0] compare_of(input logic [DUTY_W-1:0] d);
      logic [CMP_PROD_W-1:0] prod;
      logic [DUTY_W-1:0]     off;
      off  = DUTY_FULL - d;
      prod = CMP_PROD_W'(off) * CMP_PROD_W'(CMP_RECIP);
      if (d >= DUTY_FULL) begin
         return '0;
      end
      return prod[CMP_SHIFT +: CMP_W];
   endfunction

   cfg_type cfg;

   dpsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [STEP_W-1:0]        step_ff, step_in;
   logic [7:0]               integ_ff, integ_in;
   logic [7:0]               prev_ff, prev_in;
   logic signed [7:0]        err_ff, err_in;
   logic signed [8:0]        diff_ff, diff_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [CORR_W-1:0] left_ff, left_in;
   logic signed [CORR_W-1:0] right_ff, right_in;
   logic [DUTY_W-1:0]        dl_ff, dl_in, dr_ff, dr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]        out_dl_ff, out_dl_in, out_dr_ff, out_dr_in;
   logic [CMP_W-1:0]         out_cl_ff, out_cl_in, out_cr_ff, out_cr_in;

   ctrl_type                 cw;
   logic                     in_take;
   logic                     out_free;
   logic [GAIN_W-1:0]        gain_val;
   logic signed [8:0]        opnd;
   logic signed [25:0]       prod;
   logic signed [SUM_W-1:0]  sum_l, sum_r;

   assign cw        = rom_read(step_ff);
   assign req_stall = reset || (cw.op != OP_WAIT_IN);
   assign in_take   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (cw.gain)
         REG_KP_LEFT:  gain_val = cfg.kp_left;
         REG_KI_LEFT:  gain_val = cfg.ki_left;
         REG_KD_LEFT:  gain_val = cfg.kd_left;
         REG_KP_RIGHT: gain_val = cfg.kp_right;
         REG_KI_RIGHT: gain_val = cfg.ki_right;
         REG_KD_RIGHT: gain_val = cfg.kd_right;
         default:      gain_val = '0;
      endcase
   end

   always_comb begin
      unique case (cw.src)
         SRC_ERR:   opnd = {err_ff[7], err_ff};
         SRC_INTEG: opnd = $signed({integ_ff[7], integ_ff});
         SRC_DIFF:  opnd = diff_ff;
         default:   opnd = '0;
      endcase
   end

   assign prod  = 26'($signed({1'b0, gain_val})) * 26'(opnd);
   assign sum_l = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.base_speed})
                  + {left_ff[CORR_W-1], left_ff};
   assign sum_r = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.base_speed})
                  - {right_ff[CORR_W-1], right_ff};

   always_comb begin
      step_in      = step_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      out_dl_in    = out_dl_ff;
      out_dr_in    = out_dr_ff;
      out_cl_in    = out_cl_ff;
      out_cr_in    = out_cr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cw.st_left) begin
         left_in = trunc_div(acc_ff);
      end
      if (cw.st_right) begin
         right_in = trunc_div(acc_ff);
      end

      unique case (cw.op)
         OP_WAIT_IN: begin
            if (in_take) begin
               err_in   = req_pos_error;
               integ_in = integ_ff + req_pos_error;
               diff_in  = {req_pos_error[7], req_pos_error} - $signed({prev_ff[7], prev_ff});
               prev_in  = req_pos_error;
               step_in  = cw.next;
            end
         end
         OP_MAC: begin
            acc_in  = cw.acc_add ? acc_ff + {prod[25], prod} : ACC_W'(prod);
            step_in = cw.next;
         end
         OP_CLAMP: begin
            dl_in   = clamp_duty(sum_l, cfg.max_speed);
            dr_in   = clamp_duty(sum_r, cfg.max_speed);
            step_in = cw.next;
         end
         OP_WAIT_OUT: begin
            // hold until the output register can take the word
            if (out_free) begin
               out_dl_in    = dl_ff;
               out_dr_in    = dr_ff;
               out_cl_in    = compare_of(dl_ff);
               out_cr_in    = compare_of(dr_ff);
               rsp_valid_in = 1'b1;
               step_in      = cw.next;
            end
         end
         default: begin
            step_in = cw.next;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      begin
         err_ff    <= err_in;
         diff_ff   <= diff_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         dl_ff     <= dl_in;
         dr_ff     <= dr_in;
         out_dl_ff <= out_dl_in;
         out_dr_ff <= out_dr_in;
         out_cl_ff <= out_cl_in;
         out_cr_ff <= out_cr_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty_left     = out_dl_ff;
   assign rsp_duty_right    = out_dr_ff;
   assign rsp_compare_left  = out_cl_ff;
   assign rsp_compare_right = out_cr_ff;

endmodule

`default_nettype wire

/* rtl/core/dpsp_checker.sv */
`default_nettype none

module dpsp_checker import dpsp_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [DUTY_W-1:0] rsp_duty_left,
   input wire logic [DUTY_W-1:0] rsp_duty_right,
   input wire logic [CMP_W-1:0]  rsp_compare_left,
   input wire logic [CMP_W-1:0]  rsp_compare_right
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_full_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty_left < DUTY_FULL || rsp_compare_left == '0)
                 && (rsp_duty_right < DUTY_FULL || rsp_compare_right == '0))
      else $error("nonzero compare at full duty");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && !req_stall))
      else $error("result one cycle after input word");

endmodule

bind differential_pid_steer_pwm dpsp_checker u_dpsp_checker (.*);

`default_nettype wire
